FILE: hdl/de_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// de_pkg: shared types and constants
// Widths, mode codes, config indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package de_pkg;
    localparam int MaxMembers = 64;
    localparam int MaxDims    = 16;
    localparam int ValueBits  = 32;
    localparam int MemberBits = 6;
    localparam int ElemBits   = 4;
    localparam int PopAddrBits = MemberBits + ElemBits;

    typedef logic signed [ValueBits-1:0] t_value;

    typedef enum logic [2:0] {
        MODE_LOAD_ELEM = 3'd0,
        MODE_LOAD_FIT  = 3'd1,
        MODE_TRIAL     = 3'd2,
        MODE_VERDICT   = 3'd3,
        MODE_READ_ELEM = 3'd4
    } t_mode;

    localparam logic [1:0] CFG_F_SCALE = 2'd0;
    localparam logic [1:0] CFG_CR      = 2'd1;
    localparam logic [1:0] CFG_POP     = 2'd2;
    localparam logic [1:0] CFG_DIMS    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_MUL,
        ST_SUM,
        ST_OWN,
        ST_FIT,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_READ,
        ST_DONE
    } t_state;
endpackage

FILE: hdl/differential_evolution_engine.sv
`timescale 1ns / 1ps
// Path to the strobe: loads and ignored words go to ST_DONE, read element via ST_READ,
//   trial via ST_OWN, ST_READ (own element) or ST_RD_A, ST_RD_B, ST_RD_C, ST_MUL, ST_SUM
//   (mutation), verdict via ST_FIT and, when taken, ST_COPY_RD (trial read) and ST_COPY_WR
//   (population write) per element for min(dims,16) elements. The strobe is registered
//   from ST_DONE. A new word is taken in the strobe cycle; the receiver cannot stall.
// Synchronous active-low reset restores config, best fitness (max) and index 0.
// ----------------------------------------------------------------------------
// differential_evolution_engine: DE rand/1/bin store and step unit
// Holds population, fitness and trial vector in RAMs; signed 32-bit values, F scale in Q2.14.
// ----------------------------------------------------------------------------
module differential_evolution_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          i_mode,
    input  logic [de_pkg::MemberBits-1:0]       i_member,
    input  logic [de_pkg::MemberBits-1:0]       i_pick_a,
    input  logic [de_pkg::MemberBits-1:0]       i_pick_b,
    input  logic [de_pkg::MemberBits-1:0]       i_pick_c,
    input  logic [de_pkg::ElemBits-1:0]         i_element,
    input  logic signed [de_pkg::ValueBits-1:0] i_value,
    input  logic [15:0]                         i_random_fraction,
    input  logic                                i_forced,
    input  logic signed [de_pkg::ValueBits-1:0] i_fitness,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    output logic                                o_strobe,
    output logic signed [de_pkg::ValueBits-1:0] o_element_value,
    output logic                                o_accepted,
    output logic                                o_new_best,
    output logic [de_pkg::MemberBits-1:0]       o_best_member,
    output logic signed [de_pkg::ValueBits-1:0] o_best_fitness,
    output logic                                o_status
);
    import de_pkg::*;

    localparam logic [ValueBits-1:0] VMax = {1'b0, {(ValueBits-1){1'b1}}};
    localparam logic [ValueBits-1:0] VMin = {1'b1, {(ValueBits-1){1'b0}}};

    logic [15:0]       r_f_scale;
    logic [16:0]       r_cr;
    logic [6:0]        r_pop;
    logic [4:0]        r_dims;
    t_state            r_state, n_state;
    logic [2:0]        r_mode;
    logic [MemberBits-1:0] r_x, r_b, r_c;
    logic [ElemBits-1:0]   r_e;
    t_value            r_val, r_fit;
    logic [ElemBits:0] r_cnt;
    t_value            r_va, r_vb;
    logic signed [ValueBits:0]    r_diff;
    logic signed [ValueBits+17:0] r_prod;
    t_value            r_best_val;
    logic [MemberBits-1:0] r_best_idx;
    logic              r_strobe, r_acc, r_nb, r_st;
    t_value            r_ev;

    // memories
    logic                   pop_we, fit_we, tri_we;
    logic [PopAddrBits-1:0] pop_addr;
    logic [MemberBits-1:0]  fit_addr;
    logic [ElemBits-1:0]    tri_addr;
    t_value                 pop_wdata, fit_wdata, tri_wdata;
    logic [ValueBits-1:0]   pop_q, fit_q, tri_q;

    de_ram #(.Width(ValueBits), .Depth(MaxMembers*MaxDims)) u_pop (
        .i_clk(i_clk), .i_we(pop_we), .i_addr(pop_addr),
        .i_wdata(pop_wdata), .o_rdata(pop_q));
    de_ram #(.Width(ValueBits), .Depth(MaxMembers)) u_fit (
        .i_clk(i_clk), .i_we(fit_we), .i_addr(fit_addr),
        .i_wdata(fit_wdata), .o_rdata(fit_q));
    de_ram #(.Width(ValueBits), .Depth(MaxDims)) u_tri (
        .i_clk(i_clk), .i_we(tri_we), .i_addr(tri_addr),
        .i_wdata(tri_wdata), .o_rdata(tri_q));

    logic accept;
    logic xok, eok, pok, ok;
    logic [ElemBits:0] nd;
    logic signed [ValueBits+18:0] sum;
    t_value sat;

    assign accept = start && !busy;
    assign busy = (r_state != ST_IDLE);
    // hold config off while busy or while a word is offered
    assign o_cfg_ready = !busy && !start;
    assign nd = (r_dims > 5'(MaxDims)) ? (ElemBits+1)'(MaxDims) : r_dims[ElemBits:0];

    always_comb begin
        xok = {1'b0, i_member} < r_pop;
        eok = {1'b0, i_element} < nd;
        pok = ({1'b0, i_pick_a} < r_pop) && ({1'b0, i_pick_b} < r_pop)
            && ({1'b0, i_pick_c} < r_pop);
        case (i_mode)
            MODE_LOAD_ELEM, MODE_READ_ELEM: ok = xok && eok;
            MODE_LOAD_FIT, MODE_VERDICT:    ok = xok;
            MODE_TRIAL:                     ok = xok && eok && pok;
            default:                        ok = 1'b0;
        endcase
    end

    assign sum = (ValueBits+19)'(r_va) + (ValueBits+19)'(r_prod >>> 14);
    assign sat = (sum > (ValueBits+19)'(signed'(VMax))) ? t_value'(VMax) :
                 (sum < (ValueBits+19)'(signed'(VMin))) ? t_value'(VMin) :
                 t_value'(sum[ValueBits-1:0]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (!ok) begin
                        n_state = ST_DONE;
                    end else begin
                        case (i_mode)
                            MODE_LOAD_ELEM, MODE_LOAD_FIT: n_state = ST_DONE;
                            MODE_TRIAL: n_state = ({1'b0, i_random_fraction} < r_cr
                                || i_forced) ? ST_RD_A : ST_OWN;
                            MODE_VERDICT: n_state = ST_FIT;
                            default: n_state = ST_READ;
                        endcase
                    end
                end
            end
            ST_RD_A:    n_state = ST_RD_B;
            ST_RD_B:    n_state = ST_RD_C;
            ST_RD_C:    n_state = ST_MUL;
            ST_MUL:     n_state = ST_SUM;
            ST_SUM:     n_state = ST_DONE;
            ST_OWN:     n_state = ST_READ;
            ST_READ:    n_state = ST_DONE;
            ST_FIT:     n_state = ($signed(r_fit) < $signed(fit_q) && nd != '0) ?
                                  ST_COPY_RD : ST_DONE;
            ST_COPY_RD: n_state = ST_COPY_WR;
            ST_COPY_WR: n_state = (r_cnt + 1'b1 >= nd) ? ST_DONE : ST_COPY_RD;
            ST_DONE:    n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        pop_we = 1'b0; fit_we = 1'b0; tri_we = 1'b0;
        pop_addr = {r_x, r_e}; fit_addr = r_x; tri_addr = r_e;
        pop_wdata = r_val; fit_wdata = r_fit; tri_wdata = sat;
        case (r_state)
            ST_IDLE: begin
                pop_addr = {i_member, i_element};
                fit_addr = i_member;
                pop_wdata = i_value;
                fit_wdata = i_fitness;
                if (accept && ok) begin
                    pop_we = (i_mode == MODE_LOAD_ELEM);
                    fit_we = (i_mode == MODE_LOAD_FIT);
                end
                if (accept && i_mode == MODE_TRIAL) pop_addr = {i_pick_a, i_element};
            end
            ST_RD_A: pop_addr = {r_b, r_e};
            ST_RD_B: pop_addr = {r_c, r_e};
            ST_SUM:  tri_we = 1'b1;
            ST_READ: begin
                tri_wdata = pop_q;
                tri_we = (r_mode == MODE_TRIAL);
            end
            ST_FIT: begin
                tri_addr = '0;
                fit_we = ($signed(r_fit) < $signed(fit_q));
            end
            ST_COPY_RD: tri_addr = r_cnt[ElemBits-1:0];
            ST_COPY_WR: begin
                pop_addr = {r_x, r_cnt[ElemBits-1:0]};
                pop_wdata = tri_q;
                pop_we = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_f_scale  <= 16'd16384;
            r_cr       <= 17'd52429;
            r_pop      <= 7'd40;
            r_dims     <= 5'd8;
            r_best_val <= t_value'(VMax);
            r_best_idx <= '0;
            r_strobe   <= 1'b0;
            r_acc      <= 1'b0;
            r_nb       <= 1'b0;
            r_st       <= 1'b0;
            r_ev       <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= (r_state == ST_DONE);
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_F_SCALE: r_f_scale <= i_cfg_data[15:0];
                    CFG_CR:      r_cr      <= i_cfg_data[16:0];
                    CFG_POP:     r_pop     <= i_cfg_data[6:0];
                    CFG_DIMS:    r_dims    <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_acc <= 1'b0;
                r_nb  <= 1'b0;
                r_st  <= !ok;
                r_ev  <= (ok && i_mode == MODE_LOAD_ELEM) ? i_value : '0;
            end
            if (r_state == ST_SUM) r_ev <= sat;
            if (r_state == ST_READ) r_ev <= pop_q;
            if (r_state == ST_FIT && $signed(r_fit) < $signed(fit_q)) begin
                r_acc <= 1'b1;
                if ($signed(r_fit) < $signed(r_best_val)) begin
                    r_nb       <= 1'b1;
                    r_best_val <= r_fit;
                    r_best_idx <= r_x;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= i_mode; r_x <= i_member;
            r_b <= i_pick_b; r_c <= i_pick_c; r_e <= i_element;
            r_val <= i_value; r_fit <= i_fitness;
            r_cnt <= '0;
        end
        case (r_state)
            ST_RD_A: r_va <= pop_q;
            ST_RD_B: r_vb <= pop_q;
            ST_RD_C: r_diff <= (ValueBits+1)'(r_vb) - (ValueBits+1)'($signed(pop_q));
            ST_COPY_WR: r_cnt <= r_cnt + 1'b1;
            default: ;
        endcase
    end

    // product, registered after the difference
    logic signed [ValueBits+17:0] prod_c;
    assign prod_c = (ValueBits+18)'(r_diff) * $signed({2'b0, r_f_scale});
    always_ff @(posedge i_clk) begin
        if (r_state == ST_MUL) r_prod <= prod_c;
    end

    assign o_strobe        = r_strobe;
    assign o_element_value = r_ev;
    assign o_accepted      = r_acc;
    assign o_new_best      = r_nb;
    assign o_best_member   = r_best_idx;
    assign o_best_fitness  = r_best_val;
    assign o_status        = r_st;

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe) else $error("strobe held two cycles");
    a_idle_at_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> !busy) else $error("busy during result strobe");
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy) else $error("word taken without going busy");
    a_ignored_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_st) |-> (!r_acc && !r_nb)) else $error("ignored word flagged");
endmodule

FILE: hdl/de_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// de_ram: generic single-port RAM
// One access per cycle (a write returns the old data of that address), read data registered.
// ----------------------------------------------------------------------------
module de_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: tb/sv/differential_evolution_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// differential_evolution_engine_tb: self-checking regression for the DE unit
// Drives load, trial, verdict and read commands over several register
// settings. A scoreboard tracks population, fitness, trial vector and best
// fitness, predicts every result word and checks it in order.
// ----------------------------------------------------------------------------
module differential_evolution_engine_tb;
    import de_pkg::*;

    localparam int CycleLimit = 600000;
    localparam int TailCycles = 50;

    typedef struct {
        logic [2:0]            mode;
        logic [MemberBits-1:0] member;
        logic [MemberBits-1:0] pick_a;
        logic [MemberBits-1:0] pick_b;
        logic [MemberBits-1:0] pick_c;
        logic [ElemBits-1:0]   element;
        t_value                value;
        logic [15:0]           rnd;
        logic                  forced;
        t_value                fitness;
    } de_cmd_t;

    typedef struct packed {
        t_value                elem_val;
        logic                  acc;
        logic                  nbest;
        logic [MemberBits-1:0] bmember;
        t_value                bfit;
        logic                  status;
    } de_word_t;

    class de_scoreboard;
        t_value                pop_mem[MaxMembers*MaxDims];
        t_value                fit_mem[MaxMembers];
        t_value                trial_mem[MaxDims];
        t_value                best_val;
        logic [MemberBits-1:0] best_idx;
        logic [15:0]           f_scale;
        logic [16:0]           cr;
        logic [6:0]            pop_size;
        logic [4:0]            dims;
        de_word_t              expected_words[$];
        int errors, checked, n_ok, n_ign, n_acc, n_best;

        function new();
            for (int i = 0; i < MaxMembers*MaxDims; i++) pop_mem[i] = '0;
            for (int i = 0; i < MaxMembers; i++) fit_mem[i] = '0;
            for (int i = 0; i < MaxDims; i++) trial_mem[i] = '0;
            best_val = 32'sh7fffffff;
            best_idx = '0;
            f_scale = 16'd16384;
            cr = 17'd52429;
            pop_size = 7'd40;
            dims = 5'd8;
        endfunction

        function int members_in_use();
            return (pop_size < MaxMembers) ? int'(pop_size) : MaxMembers;
        endfunction

        function int dims_in_use();
            return (dims < MaxDims) ? int'(dims) : MaxDims;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] d);
            case (idx)
                CFG_F_SCALE: f_scale = d[15:0];
                CFG_CR:      cr = d[16:0];
                CFG_POP:     pop_size = d[6:0];
                CFG_DIMS:    dims = d[4:0];
                default: ;
            endcase
        endfunction

        // a + floor(F * (b - c) / 2^14), saturated to 32 bits
        function t_value mutate(t_value a, t_value b, t_value c);
            longint d, s;
            d = longint'(b) - longint'(c);
            s = longint'(a) + ((d * longint'({48'd0, f_scale})) >>> 14);
            if (s > 64'sd2147483647) return 32'sh7fffffff;
            if (s < -64'sd2147483648) return 32'sh80000000;
            return t_value'(s[31:0]);
        endfunction

        function void note_item(de_cmd_t it);
            de_word_t w;
            int np, nd;
            bit xok, eok, pok;
            np = members_in_use();
            nd = dims_in_use();
            xok = int'(it.member) < np;
            eok = int'(it.element) < nd;
            pok = int'(it.pick_a) < np && int'(it.pick_b) < np && int'(it.pick_c) < np;
            w.elem_val = '0;
            w.acc = 1'b0;
            w.nbest = 1'b0;
            w.status = 1'b0;
            case (it.mode)
                MODE_LOAD_ELEM: begin
                    if (xok && eok) begin
                        pop_mem[it.member*MaxDims + it.element] = it.value;
                        w.elem_val = it.value;
                    end else w.status = 1'b1;
                end
                MODE_LOAD_FIT: begin
                    if (xok) fit_mem[it.member] = it.fitness;
                    else w.status = 1'b1;
                end
                MODE_TRIAL: begin
                    if (xok && eok && pok) begin
                        if ({1'b0, it.rnd} < cr || it.forced)
                            w.elem_val = mutate(pop_mem[it.pick_a*MaxDims + it.element],
                                                pop_mem[it.pick_b*MaxDims + it.element],
                                                pop_mem[it.pick_c*MaxDims + it.element]);
                        else
                            w.elem_val = pop_mem[it.member*MaxDims + it.element];
                        trial_mem[it.element] = w.elem_val;
                    end else w.status = 1'b1;
                end
                MODE_VERDICT: begin
                    if (xok) begin
                        if (it.fitness < fit_mem[it.member]) begin
                            for (int i = 0; i < nd; i++)
                                pop_mem[it.member*MaxDims + i] = trial_mem[i];
                            fit_mem[it.member] = it.fitness;
                            w.acc = 1'b1;
                            n_acc++;
                            if (it.fitness < best_val) begin
                                best_val = it.fitness;
                                best_idx = it.member;
                                w.nbest = 1'b1;
                                n_best++;
                            end
                        end
                    end else w.status = 1'b1;
                end
                MODE_READ_ELEM: begin
                    if (xok && eok) w.elem_val = pop_mem[it.member*MaxDims + it.element];
                    else w.status = 1'b1;
                end
                default: w.status = 1'b1;
            endcase
            w.bmember = best_idx;
            w.bfit = best_val;
            if (w.status) n_ign++;
            else n_ok++;
            expected_words.push_back(w);
        endfunction

        function void check_result(de_word_t got);
            de_word_t w;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result word with nothing expected (value %h)",
                             got.elem_val);
                return;
            end
            w = expected_words.pop_front();
            checked++;
            if (got !== w) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR word %0d: exp val=%h acc=%b nb=%b bm=%0d bf=%h st=%b, got val=%h acc=%b nb=%b bm=%0d bf=%h st=%b",
                             checked, w.elem_val, w.acc, w.nbest, w.bmember, w.bfit,
                             w.status, got.elem_val, got.acc, got.nbest, got.bmember,
                             got.bfit, got.status);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] i_mode = '0;
    logic [MemberBits-1:0] i_member = '0, i_pick_a = '0, i_pick_b = '0, i_pick_c = '0;
    logic [ElemBits-1:0] i_element = '0;
    t_value i_value = '0, i_fitness = '0;
    logic [15:0] i_random_fraction = '0;
    logic i_forced = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic o_strobe, o_accepted, o_new_best, o_status;
    t_value o_element_value, o_best_fitness;
    logic [MemberBits-1:0] o_best_member;

    de_scoreboard sb = new();
    int cycles = 0;
    bit no_idle = 1'b0;

    // entries written so far; a read of anything else must never be issued
    bit pop_wr[MaxMembers][MaxDims];
    bit fit_wr[MaxMembers];
    bit trial_wr[MaxDims];

    differential_evolution_engine uut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_result('{o_element_value, o_accepted, o_new_best,
                              o_best_member, o_best_fitness, o_status});
    end

    function automatic bit hits_unwritten(de_cmd_t it);
        int np, nd;
        bit xok, eok;
        np = sb.members_in_use();
        nd = sb.dims_in_use();
        xok = int'(it.member) < np;
        eok = int'(it.element) < nd;
        case (it.mode)
            MODE_TRIAL:
                if (xok && eok && int'(it.pick_a) < np && int'(it.pick_b) < np &&
                    int'(it.pick_c) < np)
                    return !(pop_wr[it.pick_a][it.element] && pop_wr[it.pick_b][it.element] &&
                             pop_wr[it.pick_c][it.element] && pop_wr[it.member][it.element]);
            MODE_VERDICT:
                if (xok) begin
                    if (!fit_wr[it.member]) return 1'b1;
                    for (int i = 0; i < nd; i++)
                        if (!trial_wr[i]) return 1'b1;
                end
            MODE_READ_ELEM:
                if (xok && eok) return !pop_wr[it.member][it.element];
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic de_cmd_t rand_cmd();
        de_cmd_t it;
        it.mode = 3'($urandom_range(0, 7));
        it.member = 6'($urandom);
        it.pick_a = 6'($urandom);
        it.pick_b = 6'($urandom);
        it.pick_c = 6'($urandom);
        it.element = 4'($urandom);
        it.value = t_value'($urandom);
        it.rnd = 16'($urandom);
        it.forced = 1'($urandom);
        it.fitness = t_value'($urandom);
        return it;
    endfunction

    task automatic idle_gap();
        int gap, pick;
        pick = $urandom_range(0, 99);
        if (no_idle || pick < 65) gap = 0;
        else if (pick < 95) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 40);
        if (gap > 0) begin
            @(negedge i_clk) start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send(de_cmd_t it);
        int np, nd;
        np = sb.members_in_use();
        nd = sb.dims_in_use();
        @(negedge i_clk);
        start <= 1'b1;
        i_mode <= it.mode;
        i_member <= it.member;
        i_pick_a <= it.pick_a;
        i_pick_b <= it.pick_b;
        i_pick_c <= it.pick_c;
        i_element <= it.element;
        i_value <= it.value;
        i_random_fraction <= it.rnd;
        i_forced <= it.forced;
        i_fitness <= it.fitness;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
        if (int'(it.member) < np) begin
            if (it.mode == MODE_LOAD_ELEM && int'(it.element) < nd)
                pop_wr[it.member][it.element] = 1'b1;
            if (it.mode == MODE_LOAD_FIT) fit_wr[it.member] = 1'b1;
            if (it.mode == MODE_TRIAL && int'(it.element) < nd &&
                int'(it.pick_a) < np && int'(it.pick_b) < np && int'(it.pick_c) < np)
                trial_wr[it.element] = 1'b1;
        end
        idle_gap();
    endtask

    task automatic send_fields(logic [2:0] m, int x, int a, int b, int c, int e,
                               t_value val, int r, bit frc, t_value fit);
        de_cmd_t it;
        it = '{m, 6'(x), 6'(a), 6'(b), 6'(c), 4'(e), val, 16'(r), frc, fit};
        send(it);
    endtask

    task automatic fill_if_needed(int m, int e);
        if (!pop_wr[m][e])
            send_fields(MODE_LOAD_ELEM, m, 0, 0, 0, e, t_value'($urandom), 0, 0, '0);
    endtask

    // full trial vector for member x, loading any missing source element first
    task automatic build_trial(int x, int a, int b, int c);
        int nd, forced_e;
        nd = sb.dims_in_use();
        forced_e = (nd > 0) ? $urandom_range(0, nd - 1) : 0;
        for (int e = 0; e < nd; e++) begin
            fill_if_needed(a, e);
            fill_if_needed(b, e);
            fill_if_needed(c, e);
            fill_if_needed(x, e);
            send_fields(MODE_TRIAL, x, a, b, c, e, t_value'($urandom),
                        $urandom_range(0, 65535), e == forced_e, t_value'($urandom));
        end
    endtask

    task automatic run_generation_step();
        int np, x;
        t_value fit;
        np = sb.members_in_use();
        x = $urandom_range(0, np - 1);
        build_trial(x, $urandom_range(0, np - 1), $urandom_range(0, np - 1),
                    $urandom_range(0, np - 1));
        if (!fit_wr[x])
            send_fields(MODE_LOAD_FIT, x, 0, 0, 0, 0, '0, 0, 0, t_value'($urandom));
        // lean toward improvements so the copy and best paths get exercised
        if ($urandom_range(0, 3) == 0) fit = t_value'($urandom);
        else fit = sb.fit_mem[x] - t_value'($urandom_range(0, 5000));
        send_fields(MODE_VERDICT, x, 0, 0, 0, 0, '0, 0, 0, fit);
        if ($urandom_range(0, 2) == 0)
            send_fields(MODE_READ_ELEM, x, 0, 0, 0, $urandom_range(0, sb.dims_in_use() - 1),
                        '0, 0, 0, '0);
    endtask

    task automatic run_noise();
        de_cmd_t it;
        it = rand_cmd();
        if (hits_unwritten(it)) it.mode = MODE_LOAD_ELEM;
        send(it);
    endtask

    task automatic drain();
        @(negedge i_clk) start <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] d);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, d);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(int f, int cr, int pop, int nd);
        drain();
        write_reg(CFG_F_SCALE, 32'(f));
        write_reg(CFG_CR, 32'(cr));
        write_reg(CFG_POP, 32'(pop));
        write_reg(CFG_DIMS, 32'(nd));
    endtask

    task automatic run_phase(int target);
        int goal;
        goal = sb.n_ok + target;
        while (sb.n_ok < goal) begin
            no_idle = ($urandom_range(0, 7) == 0);
            if (sb.members_in_use() > 0 && sb.dims_in_use() > 0 &&
                $urandom_range(0, 9) < 7)
                run_generation_step();
            else
                run_noise();
        end
        no_idle = 1'b0;
    endtask

    task automatic directed();
        send_fields(MODE_LOAD_ELEM, 0, 0, 0, 0, 0, 32'sh7fffffff, 0, 0, '0);
        send_fields(MODE_LOAD_ELEM, 1, 0, 0, 0, 0, 32'sh80000000, 0, 0, '0);
        send_fields(MODE_LOAD_ELEM, 2, 0, 0, 0, 0, 32'sh00000000, 0, 0, '0);
        send_fields(MODE_LOAD_ELEM, 3, 0, 0, 0, 0, 32'shffffffff, 0, 0, '0);
        send_fields(MODE_READ_ELEM, 1, 0, 0, 0, 0, '0, 0, 0, '0);
        // saturate high, saturate low, then keep own element
        send_fields(MODE_TRIAL, 2, 0, 0, 1, 0, '0, 65535, 1, '0);
        send_fields(MODE_TRIAL, 2, 1, 1, 0, 0, '0, 0, 0, '0);
        send_fields(MODE_TRIAL, 3, 2, 3, 2, 0, '0, 65535, 0, '0);
        send_fields(MODE_LOAD_FIT, 2, 0, 0, 0, 0, '0, 0, 0, 32'sd100);
        build_trial(2, 0, 1, 3);
        send_fields(MODE_VERDICT, 2, 0, 0, 0, 0, '0, 0, 0, 32'sd50);
        send_fields(MODE_VERDICT, 2, 0, 0, 0, 0, '0, 0, 0, 32'sd60);
        send_fields(MODE_VERDICT, 2, 0, 0, 0, 0, '0, 0, 0, 32'sh80000000);
        send_fields(MODE_READ_ELEM, 2, 0, 0, 0, 7, '0, 0, 0, '0);
        // ignored: member, element or pick out of range, unknown modes
        send_fields(MODE_LOAD_ELEM, 40, 0, 0, 0, 0, 32'sd1, 0, 0, '0);
        send_fields(MODE_LOAD_ELEM, 0, 0, 0, 0, 8, 32'sd1, 0, 0, '0);
        send_fields(MODE_LOAD_FIT, 63, 0, 0, 0, 0, '0, 0, 0, 32'sd1);
        send_fields(MODE_TRIAL, 0, 63, 0, 1, 0, '0, 0, 1, '0);
        send_fields(MODE_VERDICT, 45, 0, 0, 0, 0, '0, 0, 0, 32'sh80000000);
        send_fields(MODE_READ_ELEM, 0, 0, 0, 0, 15, '0, 0, 0, '0);
        send_fields(3'd5, 0, 0, 0, 0, 0, '0, 0, 0, '0);
        send_fields(3'd6, 0, 0, 0, 0, 0, '0, 0, 0, '0);
        send_fields(3'd7, 0, 0, 0, 0, 0, '0, 0, 0, '0);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        directed();
        run_phase(100);

        configure(32768, 65536, 4, 1);
        run_phase(100);

        configure(0, 0, 64, 16);
        run_phase(60);
        drain();
        run_phase(60);

        configure($urandom_range(1, 32768), $urandom_range(1, 65535), 127, 31);
        run_phase(100);

        // nothing in range: every indexed word is ignored
        configure(12345, 30000, 0, 0);
        repeat (20) run_noise();

        configure($urandom_range(0, 32768), $urandom_range(0, 65536), 10, 5);
        run_phase(100);

        drain();
        repeat (TailCycles) @(posedge i_clk);

        $display("covered %0d words: %0d ok, %0d ignored, %0d verdicts taken, %0d new bests",
                 sb.n_ok + sb.n_ign, sb.n_ok, sb.n_ign, sb.n_acc, sb.n_best);
        $display("six register settings incl. extremes; %0d mismatches", sb.errors);
        if (sb.errors == 0 && sb.expected_words.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
